@@ hw/rtl/tsp_pkg.sv @@
// ============================================================================
// tsp_pkg
// Shared widths, codes and types of the trapezoid speed planner.
// ============================================================================
package tsp_pkg;

    localparam int POS_W    = 24;
    localparam int SPD_W    = 15;
    localparam int FRAC_W   = 17;
    localparam int OUT_W    = 16;
    localparam int STAT_W   = 2;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 24;
    localparam int SQ_W     = 2 * SPD_W;
    localparam int RATE_W   = 32;
    localparam int NUM_W    = 58;
    localparam int QUO_W    = 30;
    localparam int ROOT_W   = QUO_W / 2;
    localparam int CNT_W    = 5;

    localparam logic [FRAC_W-1:0] Q16_ONE   = 17'h10000;
    localparam logic [SPD_W-1:0]  SPEED_MAX = 15'h7fff;

    typedef enum logic [STAT_W-1:0] {
        STAT_RUN     = 2'd0,
        STAT_ARRIVED = 2'd1,
        STAT_BAD     = 2'd2
    } t_status;

    typedef enum logic [IDX_W-1:0] {
        REG_START_POS  = 3'd0,
        REG_END_POS    = 3'd1,
        REG_START_SPD  = 3'd2,
        REG_PEAK_SPD   = 3'd3,
        REG_FINAL_SPD  = 3'd4,
        REG_ACCEL_FRAC = 3'd5,
        REG_DECEL_FRAC = 3'd6
    } t_reg_idx;

endpackage

@@ hw/rtl/tsp_pos_if.sv @@
// ============================================================================
// tsp_pos_if
// Position request channel: valid, ready and one measured position.
// ============================================================================
interface tsp_pos_if
    import tsp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

@@ hw/rtl/tsp_res_if.sv @@
// ============================================================================
// tsp_res_if
// Result channel: valid, ready, target speed and status.
// ============================================================================
interface tsp_res_if
    import tsp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] target_speed;
    logic [STAT_W-1:0]       status;

    modport source (output valid, output target_speed, output status, input ready);
    modport sink   (input valid, input target_speed, input status, output ready);
endinterface

@@ hw/rtl/tsp_cfg_if.sv @@
// ============================================================================
// tsp_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ============================================================================
interface tsp_cfg_if
    import tsp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/tsp_root_unit.sv @@
// ============================================================================
// tsp_root_unit
// floor(sqrt(num / den)) for quotients below 2^QUO_W: bit-serial restoring
// divide, one quotient bit a cycle, then bit-serial square root, one root
// bit a cycle.
// ============================================================================
module tsp_root_unit
    import tsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [POS_W-1:0]  i_den,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    typedef enum logic [3:0] {
        RU_IDLE = 4'b0001,
        RU_DIV  = 4'b0010,
        RU_SQRT = 4'b0100,
        RU_DONE = 4'b1000
    } t_ru_state;

    t_ru_state           r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [POS_W-1:0]    r_den;
    logic [POS_W-1:0]    r_rem;
    logic [QUO_W-1:0]    r_low;
    logic [QUO_W-1:0]    r_quo;
    logic [ROOT_W+1:0]   r_srem;
    logic [ROOT_W-1:0]   r_root;

    logic [POS_W:0]      n_trial_div;
    logic [ROOT_W+3:0]   n_trial_sq;
    logic [ROOT_W+3:0]   n_sub_sq;

    assign n_trial_div = {r_rem, r_low[QUO_W-1]};
    assign n_trial_sq  = {r_srem, r_quo[QUO_W-1 -: 2]};
    assign n_sub_sq    = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RU_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                RU_IDLE: begin
                    if (i_start) begin
                        // quotient fits QUO_W bits, so the top part is below den
                        r_rem   <= i_num[QUO_W +: POS_W];
                        r_low   <= i_num[QUO_W-1:0];
                        r_den   <= i_den;
                        r_cnt   <= CNT_W'(QUO_W - 1);
                        r_state <= RU_DIV;
                    end
                end
                RU_DIV: begin
                    if (n_trial_div >= {1'b0, r_den}) begin
                        r_rem <= POS_W'(n_trial_div - {1'b0, r_den});
                        r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem <= n_trial_div[POS_W-1:0];
                        r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                    end
                    r_low <= {r_low[QUO_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_cnt   <= CNT_W'(ROOT_W - 1);
                        r_state <= RU_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                RU_SQRT: begin
                    if (n_trial_sq >= n_sub_sq) begin
                        r_srem <= (ROOT_W+2)'(n_trial_sq - n_sub_sq);
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_srem <= n_trial_sq[ROOT_W+1:0];
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_quo <= {r_quo[QUO_W-3:0], 2'b00};
                    if (r_cnt == '0) begin
                        r_state <= RU_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                RU_DONE: begin
                    r_state <= RU_IDLE;
                end
                default: r_state <= RU_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == RU_DONE);
    assign o_root = r_root;

endmodule

@@ hw/rtl/trapezoid_speed_from_position_core.sv @@
// ============================================================================
// trapezoid_speed_from_position_core
// Position-driven trapezoidal speed planner with square-root ramps.
// ============================================================================
//
//  channel   dir  handshake      payload
//  --------  ---  -------------  ---------------------------------------
//  i_pos_ch  in   valid/ready    position      s24 Q16.8
//  o_res_ch  out  valid/ready    target_speed  s16 rpm, status u2
//  i_cfg_ch  in   valid/ready    index u3, data u24 (register write)
//
//  Flow: one request at a time, taken in IDLE and left in EMIT. Arrived,
//  bad config and constant mode go from EVAL to EMIT, before-start via DIST,
//  flat or zero-length ramp via DIST and SEL. A ramp point goes on through
//  MUL, ADD, CHK and ROOT; ROOT waits for the root unit (start, 30 divide
//  steps, 15 square-root steps, done) unless the square is not positive or
//  the root saturates. The first request after re-arm also runs PLAN1-3.
//  Reset (synchronous, active low) clears registers, re-arms the plan.
//  A finished result waits in the output register while the next request
//  is taken; the result is only written back once that register is free.
//  Config writes are always ready and take effect the next cycle.
//
module trapezoid_speed_from_position_core
    import tsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    tsp_pos_if.sink i_pos_ch,
    tsp_res_if.source o_res_ch,
    tsp_cfg_if.sink i_cfg_ch
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_EVAL  = 12'b0000_0000_0010,
        ST_PLAN1 = 12'b0000_0000_0100,
        ST_PLAN2 = 12'b0000_0000_1000,
        ST_PLAN3 = 12'b0000_0001_0000,
        ST_DIST  = 12'b0000_0010_0000,
        ST_SEL   = 12'b0000_0100_0000,
        ST_MUL   = 12'b0000_1000_0000,
        ST_ADD   = 12'b0001_0000_0000,
        ST_CHK   = 12'b0010_0000_0000,
        ST_ROOT  = 12'b0100_0000_0000,
        ST_EMIT  = 12'b1000_0000_0000
    } t_state;

    localparam int PA_W = SQ_W + POS_W;
    localparam int PB_W = RATE_W + POS_W + 1;

    // config registers
    logic signed [POS_W-1:0] r_p0, r_p1;
    logic [SPD_W-1:0]        r_vs, r_vm, r_ve;
    logic [FRAC_W-1:0]       r_af, r_df;

    // plan state
    logic                     r_plan_armed;
    logic [POS_W-1:0]         r_total, r_ad, r_dd;
    logic signed [RATE_W-1:0] r_ar, r_dr;
    logic signed [OUT_W-1:0]  r_last;

    // per-request work registers
    t_state                   r_state;
    logic signed [POS_W-1:0]  r_pos;
    logic [SQ_W-1:0]          r_vs2, r_vm2, r_ve2;
    logic [POS_W-1:0]         r_s;
    logic [SQ_W-1:0]          r_sq;
    logic [POS_W-1:0]         r_den;
    logic signed [RATE_W-1:0] r_rate;
    logic [POS_W-1:0]         r_dist;
    logic [PA_W-1:0]          r_pa;
    logic signed [PB_W-1:0]   r_pb;
    logic signed [NUM_W-1:0]  r_num;
    logic [SPD_W-1:0]         r_mag;
    logic signed [OUT_W-1:0]  r_res_speed;
    t_status                  r_res_status;

    // output register
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out_speed;
    logic [STAT_W-1:0]        r_out_status;

    logic                     r_root_start;
    logic                     w_root_done;
    logic [ROOT_W-1:0]        w_root;

    logic                     w_up, w_down;
    logic                     w_arrived, w_bad, w_before;
    logic [SQ_W-1:0]          w_cprod;
    logic signed [POS_W:0]    w_dpos;
    logic signed [POS_W:0]    w_dend;
    logic signed [POS_W:0]    w_dts;
    logic [POS_W+FRAC_W-1:0]  w_ad_prod, w_dd_prod;
    logic [POS_W-1:0]         w_flat_end;
    logic signed [NUM_W-1:0]  w_num_lim;
    logic                     w_root_go;

    assign w_up      = (r_p1 > r_p0);
    assign w_down    = (r_p1 < r_p0);
    assign w_arrived = (w_down && r_pos < r_p1) || (w_up && r_pos > r_p1);
    assign w_bad     = (r_af > Q16_ONE) || (r_df > Q16_ONE) || (r_vm < r_vs);
    assign w_before  = (w_up && r_pos < r_p0) || (w_down && r_pos > r_p0);
    assign w_cprod   = r_vs * r_vm;
    assign w_dpos    = {r_pos[POS_W-1], r_pos} - {r_p0[POS_W-1], r_p0};
    assign w_dend    = {r_p1[POS_W-1], r_p1} - {r_p0[POS_W-1], r_p0};
    assign w_dts     = $signed({1'b0, r_total}) - $signed({1'b0, r_s});
    assign w_ad_prod = r_total * r_af;
    assign w_dd_prod = r_total * r_df;
    assign w_flat_end = r_total - r_dd;
    // quotient below 2^30 keeps the root within 15 bits
    assign w_num_lim = $signed({{(NUM_W-POS_W-QUO_W){1'b0}}, r_den, {QUO_W{1'b0}}});
    assign w_root_go = (r_num > 0) && (r_num < w_num_lim);

    // configuration writes
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0 <= '0;
            r_p1 <= '0;
            r_vs <= '0;
            r_vm <= '0;
            r_ve <= '0;
            r_af <= '0;
            r_df <= '0;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.index)
                REG_START_POS:  r_p0 <= i_cfg_ch.data[POS_W-1:0];
                REG_END_POS:    r_p1 <= i_cfg_ch.data[POS_W-1:0];
                REG_START_SPD:  r_vs <= i_cfg_ch.data[SPD_W-1:0];
                REG_PEAK_SPD:   r_vm <= i_cfg_ch.data[SPD_W-1:0];
                REG_FINAL_SPD:  r_ve <= i_cfg_ch.data[SPD_W-1:0];
                REG_ACCEL_FRAC: r_af <= i_cfg_ch.data[FRAC_W-1:0];
                REG_DECEL_FRAC: r_df <= i_cfg_ch.data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_pos_ch.ready = (r_state == ST_IDLE);

    // root unit start pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_start <= 1'b0;
        end else begin
            r_root_start <= (r_state == ST_CHK) && w_root_go;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_plan_armed <= 1'b1;
            r_total      <= '0;
            r_ad         <= '0;
            r_dd         <= '0;
            r_ar         <= '0;
            r_dr         <= '0;
            r_last       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && o_res_ch.ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_pos_ch.valid) begin
                        r_pos   <= i_pos_ch.position;
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_vs2 <= r_vs * r_vs;
                    r_vm2 <= r_vm * r_vm;
                    r_ve2 <= r_ve * r_ve;
                    r_res_status <= w_arrived ? STAT_ARRIVED :
                                    (w_bad ? STAT_BAD : STAT_RUN);
                    if (w_arrived) begin
                        // past the end: hold last speed, re-arm the plan
                        r_plan_armed <= 1'b1;
                        r_res_speed  <= r_last;
                        r_state      <= ST_EMIT;
                    end else if (w_bad) begin
                        r_res_speed  <= '0;
                        r_state      <= ST_EMIT;
                    end else if (r_p0 == r_p1) begin
                        // constant mode, product saturated
                        r_res_speed <= (w_cprod > SQ_W'(SPEED_MAX)) ?
                                       {1'b0, SPEED_MAX} : OUT_W'(w_cprod);
                        r_state     <= ST_EMIT;
                    end else if (r_plan_armed) begin
                        r_state <= ST_PLAN1;
                    end else begin
                        r_state <= ST_DIST;
                    end
                end
                ST_PLAN1: begin
                    r_total <= w_up ? w_dend[POS_W-1:0] : POS_W'(-w_dend);
                    r_state <= ST_PLAN2;
                end
                ST_PLAN2: begin
                    // fraction <= 1.0, so each ramp fits in POS_W bits
                    r_ad    <= w_ad_prod[16 +: POS_W];
                    r_dd    <= w_dd_prod[16 +: POS_W];
                    r_state <= ST_PLAN3;
                end
                ST_PLAN3: begin
                    r_ar <= (r_ad != '0) ?
                            $signed({2'b00, r_vm2}) - $signed({2'b00, r_vs2}) : '0;
                    r_dr <= (r_dd != '0) ?
                            $signed({2'b00, r_ve2}) - $signed({2'b00, r_vm2}) : '0;
                    r_plan_armed <= 1'b0;
                    r_state      <= ST_DIST;
                end
                ST_DIST: begin
                    if (w_before) begin
                        // before start: start speed, go straight to output
                        r_res_speed <= w_down ? -$signed({1'b0, r_vs}) : $signed({1'b0, r_vs});
                        r_state     <= ST_EMIT;
                    end else begin
                        r_s     <= w_dpos[POS_W] ? POS_W'(-w_dpos) : w_dpos[POS_W-1:0];
                        r_state <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    if (r_s < r_ad) begin
                        // accel ramp
                        r_sq    <= r_vs2;
                        r_den   <= r_ad;
                        r_rate  <= r_ar;
                        r_dist  <= r_s;
                        r_state <= ST_MUL;
                    end else if (r_s < w_flat_end) begin
                        r_res_speed <= w_down ? -$signed({1'b0, r_vm}) :
                                       $signed({1'b0, r_vm});
                        r_state     <= ST_EMIT;
                    end else if (r_dd != '0) begin
                        // decel ramp: final^2 * dd - rate * d
                        r_sq    <= r_ve2;
                        r_den   <= r_dd;
                        r_rate  <= -r_dr;
                        r_dist  <= w_dts[POS_W] ? POS_W'(-w_dts) : w_dts[POS_W-1:0];
                        r_state <= ST_MUL;
                    end else begin
                        r_res_speed <= w_down ? -$signed({1'b0, r_ve}) :
                                       $signed({1'b0, r_ve});
                        r_state     <= ST_EMIT;
                    end
                end
                ST_MUL: begin
                    r_pa    <= r_sq * r_den;
                    r_pb    <= r_rate * $signed({1'b0, r_dist});
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_num   <= $signed({{(NUM_W-PA_W){1'b0}}, r_pa}) +
                               NUM_W'(r_pb);
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (r_num > 0 && !w_root_go) begin
                        // quotient at or above 2^30: root saturates
                        r_mag <= SPEED_MAX;
                    end else begin
                        // square not positive, or root unit gives the speed
                        r_mag <= '0;
                    end
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    // waits for the root unit when it was started
                    if (!r_root_start && (w_root_done || r_mag != '0 ||
                                          r_num <= 0)) begin
                        if (w_root_done) begin
                            r_res_speed <= w_down ? -$signed({1'b0, w_root}) :
                                           $signed({1'b0, w_root});
                        end else begin
                            r_res_speed <= w_down ? -$signed({1'b0, r_mag}) :
                                           $signed({1'b0, r_mag});
                        end
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || o_res_ch.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_speed  <= r_res_speed;
                        r_out_status <= r_res_status;
                        if (r_res_status != STAT_ARRIVED) begin
                            r_last <= r_res_speed;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    tsp_root_unit u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_root_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    assign o_res_ch.valid        = r_out_valid;
    assign o_res_ch.target_speed = r_out_speed;
    assign o_res_ch.status       = r_out_status;

endmodule

@@ tb/sv/tb_trapezoid_speed_from_position_core.sv @@
// ============================================================================
// tb_trapezoid_speed_from_position_core
// Self-checking bench: drives positions and register writes, predicts each
// target speed and status, and checks every result in order.
// ============================================================================
module tb_trapezoid_speed_from_position_core;
    import tsp_pkg::*;

    localparam int QUIET_CYCLES = 90;   // outlasts the longest request plus output stalls
    localparam int N_POS        = 1700;
    localparam int MAX_REPORT   = 10;

    typedef struct packed {
        logic signed [OUT_W-1:0] speed;
        logic [STAT_W-1:0]       status;
    } t_result;

    typedef struct packed {
        logic             is_cfg;
        t_reg_idx         idx;
        logic [CFG_W-1:0] data;
    } t_request;

    logic i_clk;
    logic i_rst_n;

    tsp_pos_if pos_if ();
    tsp_res_if res_if ();
    tsp_cfg_if cfg_if ();

    trapezoid_speed_from_position_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pos_ch (pos_if),
        .o_res_ch (res_if),
        .i_cfg_ch (cfg_if)
    );

    // ------------------------------------------------------------------
    // Planner mirror: registers and plan state
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] m_start_pos, m_end_pos;
    logic [SPD_W-1:0]        m_start_spd, m_peak_spd, m_final_spd;
    logic [FRAC_W-1:0]       m_accel_frac, m_decel_frac;
    logic                    m_armed;
    longint                  m_total, m_accel_len, m_decel_len, m_accel_rate, m_decel_rate;
    logic signed [OUT_W-1:0] m_last_speed;

    t_request pending_q[$];
    t_result  speed_q[$];

    int  n_pos_queued;
    int  n_sent;
    int  n_errors;
    int  quiet;
    logic calm;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int root_clip(longint num, longint den);
        longint unsigned r;
        if (num <= 0 || den <= 0) return 0;
        r = int_sqrt(longint'(num / den));
        return (r > 32767) ? 32767 : int'(r);
    endfunction

    function automatic void write_reg(t_reg_idx idx, logic [CFG_W-1:0] d);
        case (idx)
            REG_START_POS:  m_start_pos  = d[POS_W-1:0];
            REG_END_POS:    m_end_pos    = d[POS_W-1:0];
            REG_START_SPD:  m_start_spd  = d[SPD_W-1:0];
            REG_PEAK_SPD:   m_peak_spd   = d[SPD_W-1:0];
            REG_FINAL_SPD:  m_final_spd  = d[SPD_W-1:0];
            REG_ACCEL_FRAC: m_accel_frac = d[FRAC_W-1:0];
            REG_DECEL_FRAC: m_decel_frac = d[FRAC_W-1:0];
            default: ;
        endcase
    endfunction

    // Expected answer for one position; updates the plan state.
    function automatic t_result plan_speed(logic signed [POS_W-1:0] position);
        longint p0, p1, pos, vs, vm, ve, s, d;
        int      spd;
        t_result r;
        p0 = m_start_pos;
        p1 = m_end_pos;
        pos = position;
        vs = m_start_spd;
        vm = m_peak_spd;
        ve = m_final_spd;
        r.status = STAT_RUN;
        // past the end: hold last speed, re-arm
        if ((p1 < p0 && pos < p1) || (p1 > p0 && pos > p1)) begin
            m_armed = 1'b1;
            r.speed = m_last_speed;
            r.status = STAT_ARRIVED;
            return r;
        end
        if (m_accel_frac > Q16_ONE || m_decel_frac > Q16_ONE || vm < vs) begin
            spd = 0;
            r.status = STAT_BAD;
        end else if (p0 == p1) begin
            spd = (vs * vm > 32767) ? 32767 : int'(vs * vm);
        end else begin
            if (m_armed) begin
                m_armed = 1'b0;
                m_total = (p1 > p0) ? p1 - p0 : p0 - p1;
                m_accel_len = (m_total * longint'(m_accel_frac)) >>> 16;
                m_decel_len = (m_total * longint'(m_decel_frac)) >>> 16;
                m_accel_rate = (m_accel_len != 0) ? vm * vm - vs * vs : 0;
                m_decel_rate = (m_decel_len != 0) ? ve * ve - vm * vm : 0;
            end
            if ((p1 > p0 && pos < p0) || (p1 < p0 && pos > p0)) begin
                spd = int'(vs);
            end else begin
                s = (pos > p0) ? pos - p0 : p0 - pos;
                if (s < m_accel_len) begin
                    spd = root_clip(vs * vs * m_accel_len + m_accel_rate * s, m_accel_len);
                end else if (s < m_total - m_decel_len) begin
                    spd = int'(vm);
                end else begin
                    d = (m_total > s) ? m_total - s : s - m_total;
                    if (m_decel_len > 0)
                        spd = root_clip(ve * ve * m_decel_len - m_decel_rate * d,
                                        m_decel_len);
                    else
                        spd = int'(ve);
                end
            end
            if (p1 < p0) spd = -spd;
        end
        m_last_speed = spd[OUT_W-1:0];
        r.speed = m_last_speed;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus queue helpers
    // ------------------------------------------------------------------
    task automatic q_cfg(t_reg_idx idx, longint v);
        t_request it;
        it.is_cfg = 1'b1;
        it.idx = idx;
        it.data = v[CFG_W-1:0];
        pending_q.push_back(it);
    endtask

    task automatic q_pos(longint v);
        t_request it;
        it.is_cfg = 1'b0;
        it.idx = REG_START_POS;
        it.data = v[CFG_W-1:0];
        pending_q.push_back(it);
        n_pos_queued++;
    endtask

    task automatic q_all(longint p0, longint p1, longint vs, longint vm, longint ve,
                         longint af, longint df);
        q_cfg(REG_START_POS, p0);
        q_cfg(REG_END_POS, p1);
        q_cfg(REG_START_SPD, vs);
        q_cfg(REG_PEAK_SPD, vm);
        q_cfg(REG_FINAL_SPD, ve);
        q_cfg(REG_ACCEL_FRAC, af);
        q_cfg(REG_DECEL_FRAC, df);
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and stimulus
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        longint p0, p1, span, dir, vs, vm, ve, af, df, step;
        int     ph, k, n;
        i_rst_n <= 1'b0;
        n_pos_queued = 0;

        // reset registers: constant mode with zero speeds
        q_pos(-8388608);
        q_pos(8388607);
        // upward move, all three segments
        q_all(-25600, 25600, 100, 3000, 50, 16384, 16384);
        q_pos(-8388608);          // before start
        q_pos(-25601);
        q_pos(-25600);            // ramp up at zero
        q_pos(-20000);
        q_pos(0);                 // plateau
        q_pos(20000);             // ramp down
        q_pos(25600);             // exactly at end
        q_pos(25601);             // arrived, holds last speed
        q_pos(8388607);
        q_pos(-25000);            // re-armed plan
        // stale plan: speeds raised, plan not recomputed -> overflow clip
        q_cfg(REG_START_SPD, 32767);
        q_cfg(REG_PEAK_SPD, 32767);
        q_pos(-20000);
        // stale plan, final speed dropped
        q_all(0, 10000, 0, 1000, 3000, 0, 65536);
        q_pos(5000);
        q_cfg(REG_FINAL_SPD, 0);
        q_pos(9000);
        // bad configurations
        q_cfg(REG_ACCEL_FRAC, 131071);
        q_pos(100);
        q_all(0, 10000, 200, 100, 0, 1000, 1000);
        q_pos(100);
        // downward move, zero ramp fractions; the earlier plan is still in use
        q_all(8388607, -8388608, 0, 32767, 32767, 0, 0);
        q_pos(8388607);
        q_pos(0);
        q_pos(-8388608);
        // constant mode saturation
        q_all(777, 777, 32767, 32767, 32767, 65536, 65536);
        q_pos(0);

        ph = 0;
        while (n_pos_queued < N_POS) begin
            dir = ($urandom_range(1) != 0) ? 1 : -1;
            if ($urandom_range(7) == 0) begin
                p0 = longint'($signed($urandom_range(24'hffffff)) <<< 8) >>> 8;
                p0 = $signed(p0[POS_W-1:0]);
                p1 = $signed({$urandom} & 32'hffffff);
                p1 = longint'($signed(p1[POS_W-1:0]));
            end else begin
                p0 = longint'($urandom_range(4000)) - 2000;
                span = $urandom_range(4000, 1);
                p1 = ($urandom_range(11) == 0) ? p0 : p0 + dir * span;
            end
            p0 = longint'($signed(p0[POS_W-1:0]));
            p1 = longint'($signed(p1[POS_W-1:0]));
            vm = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(200);
            vs = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(vm);
            ve = ($urandom_range(1) != 0) ? $urandom_range(vm) : $urandom_range(32767);
            case ($urandom_range(9))
                0:       af = 0;
                1:       af = 65536;
                2:       af = $urandom_range(131071);
                default: af = $urandom_range(65536);
            endcase
            case ($urandom_range(9))
                0:       df = 0;
                1:       df = 65536;
                2:       df = $urandom_range(131071);
                default: df = $urandom_range(65536);
            endcase
            if (ph % 7 == 3) begin
                // keep the current plan, change speeds only
                q_cfg(REG_START_SPD, vs);
                q_cfg(REG_PEAK_SPD, vm);
                q_cfg(REG_FINAL_SPD, ve);
            end else begin
                q_all(p0, p1, vs, vm, ve, af, df);
            end
            ph++;
            span = (p1 > p0) ? p1 - p0 : p0 - p1;
            dir = (p1 >= p0) ? 1 : -1;
            step = span / 25 + 1;
            // sweep along the move from behind the start to past the end
            for (k = -3; k <= 28; k++) begin
                if ($urandom_range(9) == 0)
                    q_pos($urandom_range(24'hffffff));
                else
                    q_pos(p0 + dir * (k * step + longint'($urandom_range(step)) - step / 2));
            end
            n = $urandom_range(6);
            for (k = 0; k < n; k++)
                q_pos(p0 + dir * longint'($urandom_range(span + 2)));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || pos_if.valid || cfg_if.valid || speed_q.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && speed_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: positions and register writes from the pending queue.
    // Writes go out only after every result is back and the core is quiet.
    // ------------------------------------------------------------------
    logic     pos_acc, cfg_acc, nv_pos, nv_cfg;
    t_request nxt;

    // no idling in a long stretch of the run
    assign calm = (n_sent >= 700 && n_sent < 1000);

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pos_if.valid <= 1'b0;
            pos_if.position <= '0;
            cfg_if.valid <= 1'b0;
            cfg_if.index <= REG_START_POS;
            cfg_if.data <= '0;
            m_start_pos = '0; m_end_pos = '0;
            m_start_spd = '0; m_peak_spd = '0; m_final_spd = '0;
            m_accel_frac = '0; m_decel_frac = '0;
            m_armed = 1'b1;
            m_total = 0; m_accel_len = 0; m_decel_len = 0;
            m_accel_rate = 0; m_decel_rate = 0;
            m_last_speed = '0;
            n_sent = 0;
            quiet <= 0;
        end else begin
            pos_acc = pos_if.valid && pos_if.ready;
            cfg_acc = cfg_if.valid && cfg_if.ready;
            if (pos_acc) begin
                speed_q.push_back(plan_speed(pos_if.position));
                n_sent++;
            end
            if (cfg_acc)
                write_reg(t_reg_idx'(cfg_if.index), cfg_if.data);
            nv_pos = pos_if.valid && !pos_acc;
            nv_cfg = cfg_if.valid && !cfg_acc;
            if (!nv_pos && !nv_cfg && pending_q.size() != 0) begin
                nxt = pending_q[0];
                if (nxt.is_cfg) begin
                    if (speed_q.size() == 0 && quiet >= QUIET_CYCLES && !pos_acc) begin
                        void'(pending_q.pop_front());
                        cfg_if.index <= nxt.idx;
                        cfg_if.data <= nxt.data;
                        nv_cfg = 1'b1;
                    end
                end else if (calm || $urandom_range(99) >= 12) begin
                    void'(pending_q.pop_front());
                    pos_if.position <= nxt.data[POS_W-1:0];
                    nv_pos = 1'b1;
                end
            end
            pos_if.valid <= nv_pos;
            cfg_if.valid <= nv_cfg;
            quiet <= (nv_pos || pos_acc || speed_q.size() != 0) ? 0 : quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: result back-pressure and in-order field compare
    // ------------------------------------------------------------------
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            n_errors = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (speed_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORT)
                        $display("unexpected result: speed %0d status %0d",
                                 res_if.target_speed, res_if.status);
                end else begin
                    want = speed_q.pop_front();
                    if (res_if.target_speed !== want.speed || res_if.status !== want.status)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORT)
                            $display("mismatch: speed exp %0d got %0d, status exp %0d got %0d",
                                     want.speed, res_if.target_speed,
                                     want.status, res_if.status);
                    end
                end
            end
            res_if.ready <= calm || ($urandom_range(99) >= 12);
        end
    end

endmodule

@@ files.f @@
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_pos_if.sv
hw/rtl/tsp_res_if.sv
hw/rtl/tsp_cfg_if.sv
hw/rtl/tsp_root_unit.sv
hw/rtl/trapezoid_speed_from_position_core.sv
tb/sv/tb_trapezoid_speed_from_position_core.sv
